// ----- rtl/vector_cosine_similarity_assert.svh -----
// Assertion macros shared by the cosine similarity RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef VECTOR_COSINE_SIMILARITY_ASSERT_SVH
`define VECTOR_COSINE_SIMILARITY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vcs_pkg.sv -----
// Package for the cosine similarity block: field widths, payload structs and helpers.
// Used by vcs_root and vector_cosine_similarity; depends on nothing.
package vcs_pkg;

  // Field and datapath widths.
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned COS_W      = 16;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned MUL_W      = DIGIT_W + 1;
  localparam int unsigned MULP_W     = 2 * MUL_W;
  localparam int unsigned PROD_W     = 2 * ACC_W;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned FRAC_SHIFT = 28;
  localparam int unsigned CAND_W     = PROD_W + 2 * Q_W;
  localparam int unsigned RPQ_W      = PROD_W + Q_W;
  localparam int unsigned BIT_IDX_W  = 4;

  // Digit indexes of a 48-bit operand split into 16-bit digits.
  localparam logic [1:0] DIGIT_FIRST = 2'd0;
  localparam logic [1:0] DIGIT_LAST  = 2'd2;

  // Highest quotient bit of the Q1.14 magnitude search.
  localparam logic [BIT_IDX_W-1:0] TOP_BIT = 4'd14;

  localparam int unsigned MAX_LEN_DEFAULT = 256;

  // One element pair of the two vectors.
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_elem;
  } elem_t;

  // One similarity result.
  typedef struct packed {
    logic signed [COS_W-1:0] cosine;
    logic                    zero_norm;
    logic                    too_long;
  } result_t;

  // Request to the magnitude search unit.
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] mag_sq;
  } root_req_t;

  // Status from the magnitude search unit.
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } root_resp_t;

  // Select one 16-bit digit of a 48-bit accumulator.
  function automatic logic [DIGIT_W-1:0] acc_digit(logic [ACC_W-1:0] x, logic [1:0] idx);
    logic [DIGIT_W-1:0] d;
    unique case (idx)
      2'd0:    d = x[DIGIT_W-1:0];
      2'd1:    d = x[2*DIGIT_W-1:DIGIT_W];
      2'd2:    d = x[3*DIGIT_W-1:2*DIGIT_W];
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/vcs_root.sv -----
// Bit-serial search for the cosine magnitude: the largest q with q*q*prod <= mag_sq * 2^28.
// Depends on vcs_pkg. Shifts and adds only; a try and a compare state per quotient bit.
module vcs_root (
  input  logic               clk,
  input  logic               rst,
  input  vcs_pkg::root_req_t req,
  output vcs_pkg::root_resp_t resp
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_TRY  = 3'b010,
    R_CMP  = 3'b100
  } root_state_t;

  root_state_t                       state;
  logic [vcs_pkg::BIT_IDX_W-1:0]     bit_idx;
  logic [vcs_pkg::Q_W-1:0]           q;
  logic [vcs_pkg::CAND_W-1:0]        sq_acc;
  logic [vcs_pkg::RPQ_W-1:0]         prod_q;
  logic [vcs_pkg::CAND_W-1:0]        cand;
  logic [vcs_pkg::CAND_W-1:0]        cand_next;
  logic [vcs_pkg::CAND_W-1:0]        num;
  logic [vcs_pkg::BIT_IDX_W:0]       shift_lin;
  logic [vcs_pkg::BIT_IDX_W:0]       shift_sq;

  // (q + 2^k)^2 * P = q^2*P + (P*q) << (k+1) + P << 2k
  assign shift_lin = {1'b0, bit_idx} + 5'd1;
  assign shift_sq  = {bit_idx, 1'b0};
  assign cand_next = sq_acc
                   + (vcs_pkg::CAND_W'(prod_q) << shift_lin)
                   + (vcs_pkg::CAND_W'(req.prod) << shift_sq);

  assign num = vcs_pkg::CAND_W'({req.mag_sq, {vcs_pkg::FRAC_SHIFT{1'b0}}});

  assign resp.done = (state == R_CMP) && (bit_idx == '0);
  assign resp.q    = q;

  // Sequencer and search registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= R_IDLE;
      bit_idx <= '0;
      q       <= '0;
    end else begin
      unique case (state)
        R_IDLE: begin
          if (req.start) begin
            bit_idx <= vcs_pkg::TOP_BIT;
            q       <= '0;
            sq_acc  <= '0;
            prod_q  <= '0;
            state   <= R_TRY;
          end
        end
        R_TRY: begin
          cand  <= cand_next;
          state <= R_CMP;
        end
        R_CMP: begin
          if (cand <= num) begin
            sq_acc     <= cand;
            prod_q     <= prod_q + (vcs_pkg::RPQ_W'(req.prod) << bit_idx);
            q[bit_idx] <= 1'b1;
          end
          if (bit_idx == '0) begin
            state <= R_IDLE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= R_TRY;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/vector_cosine_similarity.sv -----
// Streaming cosine similarity of two Q4.12 vectors, result in Q1.14.
// Depends on vcs_pkg, vcs_root and vector_cosine_similarity_assert.svh.
//
//   channel  | valid        | ready        | payload            | direction
//   ---------+--------------+--------------+--------------------+----------
//   element  | elem_valid   | elem_ready   | elem (elem_t)      | in
//   result   | result_valid | result_ready | result (result_t)  | out
//
// Each element pair is captured, then a*a, b*b and a*b go through the one shared
// 17x17 multiplier. A pair beyond MAX_LEN is only captured and skips the products.
// After the pair marked last come 18 partial products of the same multiplier
// for sa*sb and |dot|^2, then the bit-serial search in vcs_root.
// A zero norm skips the products and the search.
// A finished result waits in the output register while the next vector streams in;
// only the end of the next vector stalls until that result is taken.
// Reset is synchronous and clears the accumulators, the count and all control state.
`include "vector_cosine_similarity_assert.svh"

module vector_cosine_similarity #(
  parameter int unsigned MAX_LEN = vcs_pkg::MAX_LEN_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             elem_valid,
  output logic             elem_ready,
  input  vcs_pkg::elem_t   elem,
  output logic             result_valid,
  input  logic             result_ready,
  output vcs_pkg::result_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQA  = 9'b000000010,
    S_SQB  = 9'b000000100,
    S_DOT  = 9'b000001000,
    S_FIN  = 9'b000010000,
    S_MULP = 9'b000100000,
    S_MULN = 9'b001000000,
    S_ROOT = 9'b010000000,
    S_DONE = 9'b100000000
  } vcs_state_t;

  vcs_state_t                           state;
  logic signed [vcs_pkg::ELEM_W-1:0]    elem_a_r;
  logic signed [vcs_pkg::ELEM_W-1:0]    elem_b_r;
  logic                                 last_r;
  logic [vcs_pkg::ACC_W-1:0]            dot_sum;
  logic [vcs_pkg::ACC_W-1:0]            square_sum_a;
  logic [vcs_pkg::ACC_W-1:0]            square_sum_b;
  logic [CNT_W-1:0]                     element_count;
  logic [1:0]                           pp_i;
  logic [1:0]                           pp_j;
  logic [vcs_pkg::PROD_W-1:0]           acc;
  logic [vcs_pkg::PROD_W-1:0]           prod;
  logic [vcs_pkg::PROD_W-1:0]           mag_sq;
  logic                                 zero_flag;

  logic signed [vcs_pkg::MUL_W-1:0]     mul_x;
  logic signed [vcs_pkg::MUL_W-1:0]     mul_y;
  logic signed [vcs_pkg::MULP_W-1:0]    mul_p;
  logic [vcs_pkg::ACC_W-1:0]            mul_ext;
  logic [2:0]                           digit_sum;
  logic [6:0]                           pp_shift;
  logic [vcs_pkg::PROD_W-1:0]           term;
  logic                                 pp_last;
  logic                                 dot_neg;
  logic [vcs_pkg::ACC_W-1:0]            dot_mag;
  logic                                 result_load;
  logic signed [vcs_pkg::COS_W-1:0]     cos_val;
  vcs_pkg::root_req_t                   root_req;
  vcs_pkg::root_resp_t                  root_resp;

  assign elem_ready = (state == S_IDLE);

  // Magnitude and sign of the dot product.
  assign dot_neg = dot_sum[vcs_pkg::ACC_W-1];
  assign dot_mag = dot_neg ? (~dot_sum + 1'b1) : dot_sum;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      S_SQA: begin
        mul_x = {elem_a_r[vcs_pkg::ELEM_W-1], elem_a_r};
        mul_y = {elem_a_r[vcs_pkg::ELEM_W-1], elem_a_r};
      end
      S_SQB: begin
        mul_x = {elem_b_r[vcs_pkg::ELEM_W-1], elem_b_r};
        mul_y = {elem_b_r[vcs_pkg::ELEM_W-1], elem_b_r};
      end
      S_DOT: begin
        mul_x = {elem_a_r[vcs_pkg::ELEM_W-1], elem_a_r};
        mul_y = {elem_b_r[vcs_pkg::ELEM_W-1], elem_b_r};
      end
      S_MULP: begin
        mul_x = {1'b0, vcs_pkg::acc_digit(square_sum_a, pp_i)};
        mul_y = {1'b0, vcs_pkg::acc_digit(square_sum_b, pp_j)};
      end
      S_MULN: begin
        mul_x = {1'b0, vcs_pkg::acc_digit(dot_mag, pp_i)};
        mul_y = {1'b0, vcs_pkg::acc_digit(dot_mag, pp_j)};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p   = mul_x * mul_y;
  assign mul_ext = {{(vcs_pkg::ACC_W - vcs_pkg::MULP_W){mul_p[vcs_pkg::MULP_W-1]}}, mul_p};

  // Partial product of two unsigned digits, placed at its digit weight.
  assign digit_sum = {1'b0, pp_i} + {1'b0, pp_j};
  assign pp_shift  = {digit_sum, 4'b0000};
  assign term      = vcs_pkg::PROD_W'(mul_p[2*vcs_pkg::DIGIT_W-1:0]) << pp_shift;
  assign pp_last   = (pp_i == vcs_pkg::DIGIT_LAST) && (pp_j == vcs_pkg::DIGIT_LAST);

  // Magnitude search over the two wide products.
  assign root_req.start  = (state == S_MULN) && pp_last;
  assign root_req.prod   = prod;
  assign root_req.mag_sq = mag_sq;

  vcs_root u_root (
    .clk  (clk),
    .rst  (rst),
    .req  (root_req),
    .resp (root_resp)
  );

  // Result value and output register load.
  assign cos_val = zero_flag ? '0
                 : (dot_neg ? -$signed({1'b0, root_resp.q}) : $signed({1'b0, root_resp.q}));
  assign result_load = (state == S_DONE) && (!result_valid || result_ready);

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      dot_sum       <= '0;
      square_sum_a  <= '0;
      square_sum_b  <= '0;
      element_count <= '0;
      pp_i          <= vcs_pkg::DIGIT_FIRST;
      pp_j          <= vcs_pkg::DIGIT_FIRST;
      zero_flag     <= 1'b0;
    end else begin
      // The output register fills on a load and empties when its transaction is taken.
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (elem_valid) begin
            elem_a_r <= elem.elem_a;
            elem_b_r <= elem.elem_b;
            last_r   <= elem.last_elem;
            if (element_count < CNT_MAX) begin
              element_count <= element_count + 1'b1;
              state         <= S_SQA;
            end else begin
              element_count <= CNT_LIMIT;
              if (elem.last_elem) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_SQA: begin
          square_sum_a <= square_sum_a + mul_ext;
          state        <= S_SQB;
        end
        S_SQB: begin
          square_sum_b <= square_sum_b + mul_ext;
          state        <= S_DOT;
        end
        S_DOT: begin
          dot_sum <= dot_sum + mul_ext;
          state   <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          pp_i <= vcs_pkg::DIGIT_FIRST;
          pp_j <= vcs_pkg::DIGIT_FIRST;
          acc  <= '0;
          if ((square_sum_a == '0) || (square_sum_b == '0)) begin
            zero_flag <= 1'b1;
            state     <= S_DONE;
          end else begin
            zero_flag <= 1'b0;
            state     <= S_MULP;
          end
        end
        S_MULP, S_MULN: begin
          if (pp_last) begin
            if (state == S_MULP) begin
              prod  <= acc + term;
              state <= S_MULN;
            end else begin
              mag_sq <= acc + term;
              state  <= S_ROOT;
            end
            acc  <= '0;
            pp_i <= vcs_pkg::DIGIT_FIRST;
            pp_j <= vcs_pkg::DIGIT_FIRST;
          end else begin
            acc <= acc + term;
            if (pp_j == vcs_pkg::DIGIT_LAST) begin
              pp_j <= vcs_pkg::DIGIT_FIRST;
              pp_i <= pp_i + 1'b1;
            end else begin
              pp_j <= pp_j + 1'b1;
            end
          end
        end
        S_ROOT: begin
          if (root_resp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (result_load) begin
            result.cosine    <= cos_val;
            result.zero_norm <= zero_flag;
            result.too_long  <= (element_count > CNT_MAX);
            dot_sum          <= '0;
            square_sum_a     <= '0;
            square_sum_b     <= '0;
            element_count    <= '0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the result and on the sequencer.
  `VCS_ASSERT_SAME(a_zero_norm_cos, result_valid && result.zero_norm, result.cosine == '0, "zero norm result with nonzero cosine")
  `VCS_ASSERT_SAME(a_cos_range, result_valid, (result.cosine <= 16'sd16384) && (result.cosine >= -16'sd16384), "cosine outside unit range")
  `VCS_ASSERT_SAME(a_count_limit, 1'b1, element_count <= CNT_LIMIT, "element count beyond saturation")
  `VCS_ASSERT_NEXT(a_clear_after_load, result_load, (dot_sum == '0) && (square_sum_a == '0) && (element_count == '0), "state not cleared after result")
  `VCS_ASSERT_SAME(a_root_done_state, root_resp.done, state == S_ROOT, "search finished outside its phase")

endmodule

// ----- tb/vector_cosine_similarity_tb.sv -----
// Self-checking testbench for vector_cosine_similarity: streams element pairs,
// predicts each Q1.14 cosine result and checks it. Depends on vcs_pkg and the RTL.
`timescale 1ns / 1ps

module vector_cosine_similarity_tb;

  localparam int unsigned VEC_MAX_LEN = vcs_pkg::MAX_LEN_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT = 27;
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_REPORTS = 10;

  // Shapes of generated vector pairs.
  typedef enum {
    SHAPE_MIXED,
    SHAPE_SAME,
    SHAPE_NEGATED,
    SHAPE_SCALED,
    SHAPE_ZERO_A,
    SHAPE_ZERO_B
  } vector_shape_e;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             elem_valid = 1'b0;
  logic             elem_ready;
  vcs_pkg::elem_t   elem = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  vcs_pkg::result_t result;

  vcs_pkg::elem_t   pending_pairs[$];
  vcs_pkg::result_t expected_cosines[$];
  int               sent_count = 0;
  int               cycle_count = 0;
  int               error_count = 0;
  logic             calm;

  // Accumulators of the similarity predictor.
  logic [vcs_pkg::ACC_W-1:0] dot_acc = '0;
  logic [vcs_pkg::ACC_W-1:0] sq_a_acc = '0;
  logic [vcs_pkg::ACC_W-1:0] sq_b_acc = '0;
  int unsigned               pair_count = 0;

  vector_cosine_similarity #(
    .MAX_LEN(VEC_MAX_LEN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .elem_valid(elem_valid),
    .elem_ready(elem_ready),
    .elem(elem),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // No idling on either side while this stretch of transactions is sent.
  assign calm = (sent_count >= 300) && (sent_count < 700);

  // Largest q with sa*sb*q^2 <= dot^2 * 2^28, found bit by bit from the top.
  function automatic logic [vcs_pkg::Q_W-1:0] cosine_root_search(
      logic [vcs_pkg::ACC_W-1:0] mag,
      logic [vcs_pkg::ACC_W-1:0] sa,
      logic [vcs_pkg::ACC_W-1:0] sb);
    logic [127:0]            norm_prod;
    logic [127:0]            target;
    logic [127:0]            trial;
    logic [vcs_pkg::Q_W-1:0] q;
    logic [vcs_pkg::Q_W-1:0] cand;
    int                      bit_idx;
    norm_prod = 128'(sa) * 128'(sb);
    target = (128'(mag) * 128'(mag)) << vcs_pkg::FRAC_SHIFT;
    q = '0;
    for (bit_idx = vcs_pkg::Q_W - 1; bit_idx >= 0; bit_idx--) begin
      cand = q | (15'd1 << bit_idx);
      trial = norm_prod * 128'(cand) * 128'(cand);
      if (trial <= target) begin
        q = cand;
      end
    end
    return q;
  endfunction

  // Accumulate one accepted pair; on the last pair queue the expected result.
  task automatic accumulate_pair(vcs_pkg::elem_t p);
    logic signed [vcs_pkg::ACC_W-1:0] prod_ab;
    logic signed [vcs_pkg::ACC_W-1:0] prod_aa;
    logic signed [vcs_pkg::ACC_W-1:0] prod_bb;
    logic                             neg;
    logic [vcs_pkg::ACC_W-1:0]        mag;
    logic [vcs_pkg::COS_W-1:0]        q_ext;
    vcs_pkg::result_t                 want;
    prod_ab = p.elem_a * p.elem_b;
    prod_aa = p.elem_a * p.elem_a;
    prod_bb = p.elem_b * p.elem_b;
    if (pair_count < VEC_MAX_LEN) begin
      dot_acc = dot_acc + prod_ab;
      sq_a_acc = sq_a_acc + prod_aa;
      sq_b_acc = sq_b_acc + prod_bb;
      pair_count++;
    end else begin
      pair_count = VEC_MAX_LEN + 1;
    end
    if (p.last_elem) begin
      want = '0;
      want.too_long = (pair_count > VEC_MAX_LEN);
      if (sq_a_acc == '0 || sq_b_acc == '0) begin
        want.zero_norm = 1'b1;
      end else begin
        neg = dot_acc[vcs_pkg::ACC_W-1];
        mag = neg ? (~dot_acc + 1'b1) : dot_acc;
        q_ext = {1'b0, cosine_root_search(mag, sq_a_acc, sq_b_acc)};
        want.cosine = neg ? (~q_ext + 1'b1) : q_ext;
      end
      expected_cosines.insert(expected_cosines.size(), want);
      dot_acc = '0;
      sq_a_acc = '0;
      sq_b_acc = '0;
      pair_count = 0;
    end
  endtask

  task automatic add_pair(logic signed [vcs_pkg::ELEM_W-1:0] a,
                          logic signed [vcs_pkg::ELEM_W-1:0] b,
                          logic last);
    vcs_pkg::elem_t p;
    p.elem_a = a;
    p.elem_b = b;
    p.last_elem = last;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Full-range, small, zero or boundary element values.
  function automatic logic signed [vcs_pkg::ELEM_W-1:0] random_elem();
    int v;
    logic signed [vcs_pkg::ELEM_W-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = $urandom_range(0, 128);
        r = 16'(v - 64);
      end
      3: begin
        case ($urandom_range(0, 4))
          0: r = 16'sh8000;
          1: r = 16'sh7fff;
          2: r = -16'sd1;
          3: r = 16'sd1;
          default: r = '0;
        endcase
      end
      4: r = '0;
      default: r = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic queue_vector(int len, vector_shape_e shape);
    logic signed [vcs_pkg::ELEM_W-1:0] a;
    logic signed [vcs_pkg::ELEM_W-1:0] b;
    logic signed [vcs_pkg::ELEM_W-1:0] noise;
    int i;
    for (i = 0; i < len; i++) begin
      a = random_elem();
      b = random_elem();
      case (shape)
        SHAPE_SAME:    b = a;
        SHAPE_NEGATED: b = -a;
        SHAPE_SCALED: begin
          b = a >>> $urandom_range(0, 3);
          noise = 16'($urandom_range(0, 6));
          b = b + noise - 16'sd3;
        end
        SHAPE_ZERO_A:  a = '0;
        SHAPE_ZERO_B:  b = '0;
        default: ;
      endcase
      add_pair(a, b, i == len - 1);
    end
  endtask

  // Stimulus, then wait for the last result and report.
  initial begin
    int            random_items;
    int            len;
    bit            long_done;
    vector_shape_e shape;

    // Single-pair extremes, including fully parallel and opposite vectors.
    add_pair(16'sh7fff, 16'sh7fff, 1'b1);
    add_pair(16'sh8000, 16'sh7fff, 1'b1);
    add_pair(16'sh8000, 16'sh8000, 1'b1);
    add_pair(16'sd1, -16'sd1, 1'b1);
    // Zero norm on the first vector, the second, and both.
    add_pair(16'sd0, 16'sd100, 1'b0);
    add_pair(16'sd0, -16'sd7, 1'b1);
    add_pair(16'sd300, 16'sd0, 1'b0);
    add_pair(-16'sd5, 16'sd0, 1'b1);
    add_pair(16'sd0, 16'sd0, 1'b1);
    // Orthogonal vectors: nonzero norms with a zero dot product.
    add_pair(16'sd4096, 16'sd0, 1'b0);
    add_pair(16'sd0, 16'sd4096, 1'b1);
    // Opposite vectors of three pairs.
    add_pair(16'sd1234, -16'sd1234, 1'b0);
    add_pair(-16'sd32767, 16'sd32767, 1'b0);
    add_pair(16'sd77, -16'sd77, 1'b1);
    // A short vector of mixed values.
    queue_vector(4, SHAPE_MIXED);

    // Random vectors, mostly short; two at and beyond the length limit.
    random_items = 0;
    long_done = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 400 && !long_done) begin
        queue_vector(VEC_MAX_LEN, SHAPE_MIXED);
        queue_vector(VEC_MAX_LEN + 3, SHAPE_MIXED);
        random_items += 2 * VEC_MAX_LEN + 3;
        long_done = 1'b1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 19))
        10, 11: shape = SHAPE_SAME;
        12, 13: shape = SHAPE_NEGATED;
        14, 15: shape = SHAPE_SCALED;
        16:     shape = SHAPE_ZERO_A;
        17:     shape = SHAPE_ZERO_B;
        default: shape = SHAPE_MIXED;
      endcase
      queue_vector(len, shape);
      random_items += len;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || elem_valid) @(posedge clk);
    while (expected_cosines.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (error_count == 0 && expected_cosines.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Element driver: a new transaction only once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else if (!elem_valid || elem_ready) begin
      if (pending_pairs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        elem <= pending_pairs.pop_front();
        elem_valid <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        elem_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each accepted pair, check each accepted result.
  always @(posedge clk) begin
    vcs_pkg::result_t want;
    if (!rst) begin
      if (elem_valid && elem_ready) begin
        accumulate_pair(elem);
      end
      if (result_valid && result_ready) begin
        if (expected_cosines.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result: cos=%0d zn=%0b tl=%0b", $signed(result.cosine),
                     result.zero_norm, result.too_long);
          end
        end else begin
          want = expected_cosines.pop_front();
          if (result.cosine != want.cosine || result.zero_norm != want.zero_norm ||
              result.too_long != want.too_long) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result mismatch: expected cos=%0d zn=%0b tl=%0b,",
                       $signed(want.cosine), want.zero_norm, want.too_long,
                       " got cos=%0d zn=%0b tl=%0b",
                       $signed(result.cosine), result.zero_norm, result.too_long);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vcs_pkg.sv
rtl/vcs_root.sv
rtl/vector_cosine_similarity.sv
tb/vector_cosine_similarity_tb.sv
